[src/wsp_pkg.sv]
// Shared types, command codes and constants of the weekly schedule positioner.
package wsp_pkg;

  localparam logic [13:0] SEG_PER_DAY  = 14'd288;
  localparam logic [13:0] SEG_MAX      = 14'd2015;
  localparam logic [13:0] EMPTY_TIME   = 14'd9999;
  localparam logic [7:0]  FULL_OPEN    = 8'd255;
  localparam logic [15:0] THRESH_RESET = 16'd3500;
  localparam int          TIME_W       = 14;
  localparam int          AMT_W        = 8;
  localparam int          ENTRY_W      = TIME_W + AMT_W;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_BATT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PK_ACK   = 2'd0,
    PK_ERR   = 2'd1,
    PK_BATT  = 2'd2,
    PK_MATCH = 2'd3
  } pend_kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  weekday;
    logic [2:0]  slot;
    logic [13:0] week_seg;
    logic [7:0]  open_amount;
    logic [15:0] battery_mv;
  } in_t;

  typedef struct packed {
    logic       moved;
    logic       direction;
    logic [8:0] half_steps;
    logic [7:0] position;
    logic       low_batt;
    logic       error;
    logic       last;
  } out_t;

  typedef struct packed {
    logic       capture;
    logic       wr_en;
    logic       ld_pend;
    pend_kind_e pend_kind;
    logic       clr_pend;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       push_out;
    logic       push_last;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic err;
    logic batt_low;
    logic latched;
    logic match;
    logic pend_vld;
    logic cnt_last;
    logic out_free;
  } dp_stat_t;

  // Day of the week for a segment that is already known to be at most SEG_MAX.
  function automatic logic [2:0] seg_day(input logic [13:0] seg);
    logic [2:0] d;
    d = 3'd0;
    for (int k = 1; k < 7; k++) begin
      if (seg >= 14'(k * 288)) d = 3'(k);
    end
    return d;
  endfunction

endpackage

[src/weekly_schedule_positioner.sv]
// Top level of the weekly schedule positioner: controller, datapath and slot table.
//
// Input channel in_valid_i/in_ready_o carries one command transaction (set slot, add
// slot, time tick, battery sample). Output channel out_valid_o/out_ready_i returns
// one or more result transactions per command; the final one has last set.
// cfg_we_i writes the battery threshold; write it only while idle.
// Set, add and battery commands, and ticks that are out of range or find the low
// battery latched, pass from decode straight to the final state, which registers the
// result and returns to idle to accept the next command. Any other tick reads the
// slot table once per slot of the day on the single table read port, with a read
// state and a compare state per slot, before it reaches the final state.
// Results sit in an output register: a command may be accepted while the previous
// final result still waits. A stalled receiver holds the block in its current step
// until the waiting result is taken; nothing is dropped.
// Reset empties all slots (valid bits), opens the vent to 255, clears the low
// battery latch and sets the threshold to 3500 mV. No clearing pass is needed.
module weekly_schedule_positioner #(
  parameter int DAYS          = 7,
  parameter int SLOTS_PER_DAY = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wsp_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wsp_pkg::out_t  out_data_o
);
  import wsp_pkg::*;

  dp_cmd_t  ctrl;
  dp_stat_t stat;

  wsp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .ctrl_o    (ctrl),
    .stat_i    (stat)
  );

  wsp_dp #(
    .DAYS         (DAYS),
    .SLOTS_PER_DAY(SLOTS_PER_DAY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .ctrl_i     (ctrl),
    .stat_o     (stat)
  );

endmodule

[src/wsp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/wsp_dp.sv]
// Datapath: item register, slot table, position and battery state, result registers.
module wsp_dp #(
  parameter int DAYS          = 7,
  parameter int SLOTS_PER_DAY = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  wsp_pkg::in_t      in_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output wsp_pkg::out_t     out_data_o,
  input  wsp_pkg::dp_cmd_t  ctrl_i,
  output wsp_pkg::dp_stat_t stat_o
);
  import wsp_pkg::*;

  localparam int Depth = DAYS * SLOTS_PER_DAY;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
  localparam logic [3:0]      DaysV   = 4'(DAYS);
  localparam logic [4:0]      SlotsV  = 5'(SLOTS_PER_DAY);
  localparam logic [7:0]      SlotsB  = 8'(SLOTS_PER_DAY);
  localparam logic [CntW-1:0] CntLast = CntW'(SLOTS_PER_DAY - 1);

  in_t              item_q;
  logic [15:0]      thr_q;
  logic [7:0]       pos_q;
  logic             latch_q;
  logic [Depth-1:0] valid_q;
  logic             rvld_q;
  logic [CntW-1:0]  cnt_q;
  out_t             pend_q;
  logic             pend_vld_q;
  out_t             out_q;
  logic             out_vld_q;

  cmd_e               cmd;
  logic [2:0]         day_of_seg;
  logic               seg_over, day_bad, set_err, add_err, tick_err, err;
  logic [2:0]         wr_day;
  logic [3:0]         wr_slot;
  logic [7:0]         wr_addr_full, rd_addr_full;
  logic [AddrW-1:0]   waddr, raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [TIME_W-1:0]  time_eff;
  logic [AMT_W-1:0]   amt_eff, target;
  logic               match, dir;
  logic [7:0]         diff;
  out_t               pend_next, ack_now, out_next;
  logic               out_free;

  assign cmd        = cmd_e'(item_q.command);
  assign day_of_seg = seg_day(item_q.week_seg);
  assign seg_over   = item_q.week_seg > SEG_MAX;
  assign day_bad    = {1'b0, day_of_seg} >= DaysV;
  assign set_err    = ({1'b0, item_q.weekday} >= DaysV) || ({2'b0, item_q.slot} >= SlotsV);
  assign add_err    = (item_q.slot == 3'd0) || ({2'b0, item_q.slot} > SlotsV) ||
                      seg_over || day_bad;
  assign tick_err   = seg_over || day_bad;

  always_comb begin
    unique case (cmd)
      CMD_SET:  err = set_err;
      CMD_ADD:  err = add_err;
      CMD_TICK: err = tick_err;
      default:  err = 1'b0;
    endcase
  end

  // Set names the day directly; add takes it from the segment and counts slots from one.
  always_comb begin
    if (cmd == CMD_SET) begin
      wr_day  = item_q.weekday;
      wr_slot = {1'b0, item_q.slot};
    end else begin
      wr_day  = day_of_seg;
      wr_slot = {1'b0, item_q.slot} - 4'd1;
    end
  end

  assign wr_addr_full = {5'b0, wr_day} * SlotsB + {4'b0, wr_slot};
  assign rd_addr_full = {5'b0, day_of_seg} * SlotsB + 8'(cnt_q);
  assign waddr        = wr_addr_full[AddrW-1:0];
  assign raddr        = rd_addr_full[AddrW-1:0];

  wsp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(Depth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.wr_en),
    .waddr_i(waddr),
    .wdata_i({item_q.week_seg, item_q.open_amount}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // A slot never written reads as empty.
  assign time_eff = rvld_q ? rdata[ENTRY_W-1:AMT_W] : EMPTY_TIME;
  assign amt_eff  = rvld_q ? rdata[AMT_W-1:0] : '0;
  assign match    = time_eff == item_q.week_seg;

  assign target = (ctrl_i.pend_kind == PK_BATT) ? FULL_OPEN : amt_eff;
  assign dir    = target > pos_q;
  assign diff   = dir ? (target - pos_q) : (pos_q - target);

  always_comb begin
    ack_now          = '0;
    ack_now.position = pos_q;
    ack_now.low_batt = latch_q;
    pend_next        = ack_now;
    case (ctrl_i.pend_kind) inside
      PK_ERR: pend_next.error = 1'b1;
      PK_BATT, PK_MATCH: begin
        pend_next.moved      = 1'b1;
        pend_next.direction  = dir;
        pend_next.half_steps = {diff, 1'b0};
        pend_next.position   = target;
        pend_next.low_batt   = (ctrl_i.pend_kind == PK_BATT) ? 1'b1 : latch_q;
      end
      default: pend_next = ack_now;
    endcase
  end

  always_comb begin
    out_next      = pend_vld_q ? pend_q : ack_now;
    out_next.last = ctrl_i.push_last;
  end

  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      item_q <= in_data_i;
    end
    if (ctrl_i.ld_pend) begin
      pend_q <= pend_next;
    end
    if (ctrl_i.push_out) begin
      out_q <= out_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THRESH_RESET;
      pos_q      <= FULL_OPEN;
      latch_q    <= 1'b0;
      valid_q    <= '0;
      rvld_q     <= 1'b0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (ctrl_i.ld_pend && ctrl_i.pend_kind == PK_BATT) begin
        latch_q <= 1'b1;
        pos_q   <= FULL_OPEN;
      end else if (ctrl_i.ld_pend && ctrl_i.pend_kind == PK_MATCH) begin
        pos_q <= amt_eff;
      end
      if (ctrl_i.wr_en) begin
        valid_q[waddr] <= 1'b1;
      end
      rvld_q <= valid_q[raddr];
      if (ctrl_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (ctrl_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (ctrl_i.clr_pend || (ctrl_i.push_out && ctrl_i.push_last)) begin
        pend_vld_q <= 1'b0;
      end else if (ctrl_i.ld_pend) begin
        pend_vld_q <= 1'b1;
      end
      if (ctrl_i.push_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    stat_o          = '0;
    stat_o.cmd      = cmd;
    stat_o.err      = err;
    stat_o.batt_low = item_q.battery_mv < thr_q;
    stat_o.latched  = latch_q;
    stat_o.match    = match;
    stat_o.pend_vld = pend_vld_q;
    stat_o.cnt_last = cnt_q == CntLast;
    stat_o.out_free = out_free;
  end

  // A waiting result must never be overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_i.push_out |-> out_free)
    else $error("result register overwritten while still waiting");

  // Low battery clears only on reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(latch_q))
    else $error("low battery latch cleared without reset");

  // A move always has an even step count and never carries an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_vld_q && out_q.moved |-> !out_q.half_steps[0] && !out_q.error)
    else $error("malformed move result");

endmodule

[src/wsp_ctrl.sv]
// Controller state machine: sequences decode, slot scan and result delivery.
module wsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output wsp_pkg::dp_cmd_t  ctrl_o,
  input  wsp_pkg::dp_stat_t stat_i
);
  import wsp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DECODE   = 5'b00010,
    S_SCAN_RD  = 5'b00100,
    S_SCAN_CMP = 5'b01000,
    S_FINAL    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        ctrl_o.ld_pend   = 1'b1;
        ctrl_o.pend_kind = PK_ACK;
        state_d          = S_FINAL;
        if (stat_i.err) begin
          ctrl_o.pend_kind = PK_ERR;
        end else begin
          unique case (stat_i.cmd) inside
            CMD_SET, CMD_ADD: ctrl_o.wr_en = 1'b1;
            CMD_BATT: begin
              if (stat_i.batt_low) ctrl_o.pend_kind = PK_BATT;
            end
            CMD_TICK: begin
              if (!stat_i.latched) begin
                ctrl_o.ld_pend  = 1'b0;
                ctrl_o.clr_pend = 1'b1;
                ctrl_o.cnt_clr  = 1'b1;
                state_d         = S_SCAN_RD;
              end
            end
            default: state_d = S_FINAL;
          endcase
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        // A new match first sends the one held back; the held one is not the last.
        if (!(stat_i.match && stat_i.pend_vld && !stat_i.out_free)) begin
          if (stat_i.match) begin
            ctrl_o.push_out  = stat_i.pend_vld;
            ctrl_o.ld_pend   = 1'b1;
            ctrl_o.pend_kind = PK_MATCH;
          end
          if (stat_i.cnt_last) begin
            state_d = S_FINAL;
          end else begin
            ctrl_o.cnt_inc = 1'b1;
            state_d        = S_SCAN_RD;
          end
        end
      end
      S_FINAL: begin
        if (stat_i.out_free) begin
          ctrl_o.push_out  = 1'b1;
          ctrl_o.push_last = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[bench/weekly_schedule_positioner_tb.sv]
// Self-checking testbench of the weekly schedule positioner: directed and random commands.
module weekly_schedule_positioner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsp_pkg::*;

  localparam int NUM_DAYS     = 7;
  localparam int NUM_SLOTS    = 5;
  localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 6;
  localparam int POOL_N       = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;

  // Predicted state of the block.
  logic [13:0] sched_time   [NUM_DAYS][NUM_SLOTS];
  logic [7:0]  sched_amount [NUM_DAYS][NUM_SLOTS];
  logic [7:0]  vent_pos;
  logic        batt_latched;
  logic [15:0] batt_threshold;

  out_t        expected_results[$];
  logic [13:0] time_pool[POOL_N];
  int          fail_count;
  int          tx_idle_pct;
  int          rx_idle_pct;

  weekly_schedule_positioner #(
    .DAYS         (NUM_DAYS),
    .SLOTS_PER_DAY(NUM_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: %h", out_data_o);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("moved", 9'(want.moved), 9'(out_data_o.moved));
        check_field("direction", 9'(want.direction), 9'(out_data_o.direction));
        check_field("half_steps", want.half_steps, out_data_o.half_steps);
        check_field("position", 9'(want.position), 9'(out_data_o.position));
        check_field("low_batt", 9'(want.low_batt), 9'(out_data_o.low_batt));
        check_field("error", 9'(want.error), 9'(out_data_o.error));
        check_field("last", 9'(want.last), 9'(out_data_o.last));
      end
    end
  end

  task automatic clear_schedule();
    for (int d = 0; d < NUM_DAYS; d++) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        sched_time[d][s]   = EMPTY_TIME;
        sched_amount[d][s] = 8'd0;
      end
    end
    vent_pos       = FULL_OPEN;
    batt_latched   = 1'b0;
    batt_threshold = THRESH_RESET;
  endtask

  task automatic push_result(input logic moved, input logic dir, input logic [8:0] half,
                             input logic err);
    out_t r;
    r.moved      = moved;
    r.direction  = dir;
    r.half_steps = half;
    r.position   = vent_pos;
    r.low_batt   = batt_latched;
    r.error      = err;
    r.last       = 1'b0;
    expected_results.push_back(r);
  endtask

  task automatic move_vent(input logic [7:0] target);
    logic       dir;
    logic [8:0] diff;
    dir  = (target > vent_pos);
    diff = dir ? 9'(target - vent_pos) : 9'(vent_pos - target);
    vent_pos = target;
    push_result(1'b1, dir, diff << 1, 1'b0);
  endtask

  task automatic predict_command(input in_t c);
    int   first;
    int   day;
    out_t tail;
    first = expected_results.size();
    day   = int'(c.week_seg) / int'(SEG_PER_DAY);
    case (c.command)
      CMD_SET: begin
        if (int'(c.weekday) < NUM_DAYS && int'(c.slot) < NUM_SLOTS) begin
          sched_time[c.weekday][c.slot]   = c.week_seg;
          sched_amount[c.weekday][c.slot] = c.open_amount;
          push_result(1'b0, 1'b0, 9'd0, 1'b0);
        end else begin
          push_result(1'b0, 1'b0, 9'd0, 1'b1);
        end
      end
      CMD_ADD: begin
        if (c.slot == 3'd0 || int'(c.slot) > NUM_SLOTS || c.week_seg > SEG_MAX ||
            day >= NUM_DAYS) begin
          push_result(1'b0, 1'b0, 9'd0, 1'b1);
        end else begin
          sched_time[day][int'(c.slot) - 1]   = c.week_seg;
          sched_amount[day][int'(c.slot) - 1] = c.open_amount;
          push_result(1'b0, 1'b0, 9'd0, 1'b0);
        end
      end
      CMD_TICK: begin
        if (c.week_seg > SEG_MAX || day >= NUM_DAYS) begin
          push_result(1'b0, 1'b0, 9'd0, 1'b1);
        end else begin
          if (!batt_latched) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
              if (sched_time[day][s] == c.week_seg) move_vent(sched_amount[day][s]);
            end
          end
          if (expected_results.size() == first) push_result(1'b0, 1'b0, 9'd0, 1'b0);
        end
      end
      default: begin
        if (c.battery_mv < batt_threshold) begin
          batt_latched = 1'b1;
          move_vent(FULL_OPEN);
        end else begin
          push_result(1'b0, 1'b0, 9'd0, 1'b0);
        end
      end
    endcase
    tail = expected_results.pop_back();
    tail.last = 1'b1;
    expected_results.push_back(tail);
  endtask

  // Valid is lowered only when a gap follows, so a back-to-back command keeps it high.
  task automatic send_command(input in_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    predict_command(c);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    batt_threshold = value;
  endtask

  function automatic in_t make_cmd(input cmd_e op, input logic [2:0] day,
                                   input logic [2:0] slot, input logic [13:0] seg,
                                   input logic [7:0] amt, input logic [15:0] mv);
    in_t c;
    c.command     = op;
    c.weekday     = day;
    c.slot        = slot;
    c.week_seg    = seg;
    c.open_amount = amt;
    c.battery_mv  = mv;
    return c;
  endfunction

  task automatic fill_time_pool();
    for (int i = 0; i < POOL_N; i++) time_pool[i] = 14'($urandom_range(int'(SEG_MAX)));
  endtask

  // Mostly well-formed commands aimed at a small pool of times so that ticks hit
  // stored slots, often several in one day; the rest is raw noise.
  function automatic in_t random_cmd(input logic allow_low);
    in_t         c;
    logic [63:0] raw;
    logic [13:0] t;
    logic [13:0] d14;
    int          pick;
    raw  = {$urandom, $urandom};
    c    = raw[$bits(in_t)-1:0];
    t    = time_pool[$urandom_range(POOL_N - 1)];
    d14  = t / SEG_PER_DAY;
    pick = $urandom_range(99);
    if (pick < 30) begin
      c.command  = CMD_ADD;
      c.slot     = 3'($urandom_range(NUM_SLOTS, 1));
      c.week_seg = t;
    end else if (pick < 45) begin
      c.command = CMD_SET;
      if ($urandom_range(3) != 0) begin
        c.weekday  = d14[2:0];
        c.slot     = 3'($urandom_range(NUM_SLOTS - 1));
        c.week_seg = t;
      end
    end else if (pick < 85) begin
      c.command = CMD_TICK;
      if ($urandom_range(4) != 0) c.week_seg = t;
      else if ($urandom_range(1) != 0) c.week_seg = 14'($urandom_range(int'(SEG_MAX)));
    end else if (pick < 93) begin
      c.command = CMD_BATT;
    end
    if (c.command == CMD_BATT && !allow_low && c.battery_mv < batt_threshold) begin
      c.battery_mv = 16'($urandom_range(65535, int'(batt_threshold)));
    end
    return c;
  endfunction

  task automatic test_directed_schedule();
    send_command(make_cmd(CMD_BATT, 3'd0, 3'd0, 14'd0, 8'd0, THRESH_RESET));
    send_command(make_cmd(CMD_BATT, 3'd7, 3'd7, 14'h3fff, 8'hff, 16'hffff));
    send_command(make_cmd(CMD_SET, 3'd0, 3'd0, 14'd0, 8'd0, 16'd0));
    send_command(make_cmd(CMD_SET, 3'd6, 3'd4, SEG_MAX, 8'd255, 16'd0));
    send_command(make_cmd(CMD_SET, 3'd7, 3'd0, 14'd10, 8'd9, 16'd0));
    send_command(make_cmd(CMD_SET, 3'd0, 3'd5, 14'd10, 8'd9, 16'd0));
    send_command(make_cmd(CMD_SET, 3'd2, 3'd7, 14'd10, 8'd9, 16'd0));
    // A set stores any time, even one no tick can ever reach.
    send_command(make_cmd(CMD_SET, 3'd1, 3'd1, 14'h3fff, 8'd77, 16'd0));
    send_command(make_cmd(CMD_ADD, 3'd0, 3'd0, 14'd100, 8'd5, 16'd0));
    send_command(make_cmd(CMD_ADD, 3'd0, 3'd6, 14'd100, 8'd5, 16'd0));
    send_command(make_cmd(CMD_ADD, 3'd0, 3'd7, 14'd100, 8'd5, 16'd0));
    send_command(make_cmd(CMD_ADD, 3'd0, 3'd1, SEG_MAX + 14'd1, 8'd5, 16'd0));
    send_command(make_cmd(CMD_ADD, 3'd0, 3'd3, 14'h3fff, 8'd255, 16'd0));
    send_command(make_cmd(CMD_ADD, 3'd0, 3'd1, SEG_PER_DAY, 8'd100, 16'd0));
    send_command(make_cmd(CMD_ADD, 3'd0, 3'd5, SEG_MAX, 8'd128, 16'd0));
    send_command(make_cmd(CMD_TICK, 3'd0, 3'd0, 14'd0, 8'd0, 16'd0));
    send_command(make_cmd(CMD_TICK, 3'd0, 3'd0, SEG_PER_DAY, 8'd0, 16'd0));
    send_command(make_cmd(CMD_TICK, 3'd0, 3'd0, SEG_MAX, 8'd0, 16'd0));
    send_command(make_cmd(CMD_TICK, 3'd0, 3'd0, SEG_MAX + 14'd1, 8'd0, 16'd0));
    send_command(make_cmd(CMD_TICK, 3'd0, 3'd0, 14'h3fff, 8'd0, 16'd0));
    // Three slots of one day at the same time: the last one does not change the position.
    send_command(make_cmd(CMD_ADD, 3'd0, 3'd2, 14'd500, 8'd200, 16'd0));
    send_command(make_cmd(CMD_ADD, 3'd0, 3'd3, 14'd500, 8'd40, 16'd0));
    send_command(make_cmd(CMD_ADD, 3'd0, 3'd4, 14'd500, 8'd40, 16'd0));
    send_command(make_cmd(CMD_TICK, 3'd0, 3'd0, 14'd500, 8'd0, 16'd0));
    send_command(make_cmd(CMD_TICK, 3'd0, 3'd0, 14'd1, 8'd0, 16'd0));
  endtask

  task automatic test_random_schedule();
    write_threshold(16'd0);
    fill_time_pool();
    repeat (30) send_command(random_cmd(1'b0));
  endtask

  task automatic test_threshold_sweep();
    logic [15:0] th;
    th = 16'($urandom_range(65534, 1));
    write_threshold(th);
    send_command(make_cmd(CMD_BATT, 3'd0, 3'd0, 14'd0, 8'd0, th));
    fill_time_pool();
    repeat (25) send_command(random_cmd(1'b0));
  endtask

  task automatic test_back_to_back();
    write_threshold(THRESH_RESET);
    repeat (15) send_command(random_cmd(1'b0));
    // The sender holds off until every pending result has been returned.
    wait_drained();
    repeat (15) send_command(random_cmd(1'b0));
  endtask

  task automatic test_low_battery();
    write_threshold(16'hffff);
    send_command(make_cmd(CMD_BATT, 3'd0, 3'd0, 14'd0, 8'd0, 16'hffff));
    write_threshold(16'd4000);
    send_command(make_cmd(CMD_BATT, 3'd0, 3'd0, 14'd0, 8'd0, 16'd4000));
    send_command(make_cmd(CMD_BATT, 3'd0, 3'd0, 14'd0, 8'd0, 16'd3999));
    // Already latched: another low sample still reports a move.
    send_command(make_cmd(CMD_BATT, 3'd0, 3'd0, 14'd0, 8'd0, 16'd0));
    for (int i = 0; i < 4; i++) begin
      send_command(make_cmd(CMD_TICK, 3'd0, 3'd0, time_pool[i], 8'd0, 16'hffff));
    end
    write_threshold(16'hffff);
    repeat (10) send_command(random_cmd(1'b1));
    write_threshold(16'd0);
    repeat (5) send_command(random_cmd(1'b1));
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 16'd0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    fail_count  = 0;
    tx_idle_pct = 17;
    rx_idle_pct = 76;
    clear_schedule();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_schedule();
    test_random_schedule();
    tx_idle_pct = 76;
    rx_idle_pct = 17;
    test_threshold_sweep();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_back_to_back();
    test_low_battery();

    wait_drained();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/wsp_pkg.sv
src/wsp_ram.sv
src/wsp_dp.sv
src/wsp_ctrl.sv
src/weekly_schedule_positioner.sv
bench/weekly_schedule_positioner_tb.sv
